/* sv/cdeq_pkg.sv */
// Shared types and constants for the circular double-ended queue.
// Depends on nothing; imported by circular_double_ended_queue.

package cdeq_pkg;

  // Word and result field widths, and the default depth
  localparam int unsigned WordW      = 32;
  localparam int unsigned FillW      = 8;
  localparam int unsigned DepthDflt  = 128;

  // Word reported when there is nothing to report
  localparam logic signed [WordW-1:0] NoneWord = '1;

  // Command codes; unlisted codes behave as peek
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

endpackage

/* sv/circular_double_ended_queue.sv */
// Circular double-ended queue: top level with pointers, count and word cache.
// Depends on cdeq_pkg and cdeq_ram.

// An item is taken when start is high and busy is low, and its result shows
// on the result ports for one cycle with result_valid_o high; the receiver
// cannot stall. Front and rear words are cached in registers, so pushes, peeks,
// refused pops and a pop of the last entry give their result in the cycle after
// the item is taken and a new item can be taken every cycle. A pop that leaves
// entries behind must fetch the new front or rear word through the slot
// memory's registered read port: it raises busy for one cycle and gives its
// result when the read word returns and refreshes the cached end. No clearing
// pass follows reset; slots are only ever read after they were written.

module circular_double_ended_queue
  import cdeq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDflt
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              cmd_i,
  input  logic signed [WordW-1:0] value_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic signed [WordW-1:0] popped_o,
  output logic signed [WordW-1:0] front_word_o,
  output logic signed [WordW-1:0] rear_word_o,
  output logic                    is_empty_o,
  output logic                    is_full_o,
  output logic [FillW-1:0]        fill_count_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Circular index steps
  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  state_e                  state_q, state_d;
  logic [AW-1:0]           head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]         count_q, count_d;
  logic signed [WordW-1:0] front_q, front_d, rear_q, rear_d;
  logic signed [WordW-1:0] popped_q, popped_d;
  status_e                 status_q, status_d;
  logic                    res_valid_q, res_valid_d;
  logic                    rd_back_q, rd_back_d;

  logic                    accept, need_read, full, empty;
  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [WordW-1:0]        rdata;

  assign accept = start & ~busy;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  // Slot store
  cdeq_ram #(
    .Width (WordW),
    .Depth (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Command decode, pointer update and word cache
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    front_d     = front_q;
    rear_d      = rear_q;
    status_d    = status_q;
    popped_d    = popped_q;
    rd_back_d   = rd_back_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = head_q;
    raddr       = head_q;
    need_read   = 1'b0;

    if (accept) begin
      status_d = STAT_OK;
      popped_d = NoneWord;
      case (cmd_e'(cmd_i))
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            head_d  = idx_prev(head_q);
            we      = 1'b1;
            waddr   = idx_prev(head_q);
            count_d = count_q + CntW'(1);
            front_d = value_i;
            if (empty) rear_d = value_i;
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            tail_d  = idx_next(tail_q);
            we      = 1'b1;
            waddr   = tail_q;
            count_d = count_q + CntW'(1);
            rear_d  = value_i;
            if (empty) front_d = value_i;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            popped_d = front_q;
            head_d   = idx_next(head_q);
            count_d  = count_q - CntW'(1);
            // fetch the new front word unless the queue drains
            if (count_q != CntW'(1)) begin
              re        = 1'b1;
              raddr     = idx_next(head_q);
              need_read = 1'b1;
              rd_back_d = 1'b0;
            end
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            popped_d = rear_q;
            tail_d   = idx_prev(tail_q);
            count_d  = count_q - CntW'(1);
            // fetch the new rear word unless the queue drains
            if (count_q != CntW'(1)) begin
              re        = 1'b1;
              raddr     = idx_prev(idx_prev(tail_q));
              need_read = 1'b1;
              rd_back_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    res_valid_d = accept & ~need_read;

    // Read data returns: refresh the cached end and release the result
    if (state_q == ST_READ) begin
      if (rd_back_q) begin
        rear_d = rdata;
      end else begin
        front_d = rdata;
      end
      res_valid_d = 1'b1;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && need_read) state_d = ST_READ;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy = 1'b0;
    unique case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_READ: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    front_q   <= front_d;
    rear_q    <= rear_d;
    status_q  <= status_d;
    popped_q  <= popped_d;
    rd_back_q <= rd_back_d;
  end

  // Result ports; state registers already hold the post-item state
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign popped_o       = popped_q;
  assign front_word_o   = empty ? NoneWord : front_q;
  assign rear_word_o    = empty ? NoneWord : rear_q;
  assign is_empty_o     = empty;
  assign is_full_o      = full;
  assign fill_count_o   = FillW'(count_q);

endmodule

/* sv/cdeq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.

module cdeq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
